FILE: rtl/amh_pkg.sv
// shared types and constants of the audio magnitude histogram
// no dependencies; every other file takes names from here by scope
`timescale 1ns / 1ps

package amh_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int BIN_OUT_W   = 8;
   localparam int COUNT_OUT_W = 32;
   localparam int SHIFT_W     = 4;
   localparam int BIN_TOTAL_W = 9;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CMP_W       = 17;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_CYCLES  = 4;
   localparam int DIV_CNT_W   = 2;
   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_PTR_W  = 1;
   localparam int FIFO_CNT_W  = 2;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DC_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_SHIFT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_THR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_TOTAL = 3'd4;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;

   typedef struct packed {
      logic                   dc_block_enable;
      logic [SHIFT_W-1:0]     dc_shift;
      logic [SAMPLE_W-1:0]    gate_threshold;
      logic [SAMPLE_W-1:0]    bin_width;
      logic [BIN_TOTAL_W-1:0] bin_total;
   } cfg_type;

   // one classified item between front and back
   typedef struct packed {
      logic                   operation;
      logic [SAMPLE_W-1:0]    sample;
      logic [BIN_OUT_W-1:0]   read_bin;
      logic                   clip;
      logic [COUNT_OUT_W-1:0] samples;
      logic [COUNT_OUT_W-1:0] clips;
   } entry_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_DIV,
      BK_READ,
      BK_UPDATE
   } back_state_type;

endpackage

FILE: rtl/amh_if.sv
// valid/ready channel interfaces: request, response and register write
// depends on amh_pkg for field widths
`timescale 1ns / 1ps

interface amh_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic signed [amh_pkg::SAMPLE_W-1:0]  sample_in;
   logic [amh_pkg::BIN_OUT_W-1:0]        read_bin;

   modport source (output valid, operation, sample_in, read_bin, input ready);
   modport sink   (input valid, operation, sample_in, read_bin, output ready);
endinterface

interface amh_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [amh_pkg::BIN_OUT_W-1:0]        bin_index;
   logic [amh_pkg::COUNT_OUT_W-1:0]      bin_count;
   logic signed [amh_pkg::SAMPLE_W-1:0]  cleaned_sample;
   logic                                 clip_seen;
   logic [amh_pkg::COUNT_OUT_W-1:0]      samples_total;
   logic [amh_pkg::COUNT_OUT_W-1:0]      clips_total;

   modport source (output valid, bin_index, bin_count, cleaned_sample, clip_seen,
                   samples_total, clips_total, input ready);
   modport sink   (input valid, bin_index, bin_count, cleaned_sample, clip_seen,
                   samples_total, clips_total, output ready);
endinterface

interface amh_csr_if;
   logic                             valid;
   logic                             ready;
   logic [amh_pkg::CSR_IDX_W-1:0]    index;
   logic [amh_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/amh_fifo.sv
// two-entry queue of classified items between front and back
// depends on amh_pkg for the entry type
`timescale 1ns / 1ps

module amh_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  amh_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output amh_pkg::entry_type pop_data,
   output logic               empty
);

   amh_pkg::entry_type                  data_ff [amh_pkg::FIFO_DEPTH];
   logic [amh_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [amh_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [amh_pkg::FIFO_CNT_W-1:0]      count_ff, count_in;

   assign full     = (count_ff == amh_pkg::FIFO_CNT_W'(amh_pkg::FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/amh_front.sv
// front end: takes items, flags clipping, runs the dc estimator and the
// sample counters, and pushes classified items; depends on amh_pkg, amh_if
`timescale 1ns / 1ps

module amh_front #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   amh_req_if.sink            req,
   input  amh_pkg::cfg_type   cfg,
   input  logic               fifo_full,
   input  logic               clearing,
   output logic               push,
   output amh_pkg::entry_type push_data
);

   localparam int EXT_W = (COUNT_WIDTH > amh_pkg::COUNT_OUT_W) ?
                          COUNT_WIDTH : amh_pkg::COUNT_OUT_W;

   logic signed [amh_pkg::SAMPLE_W-1:0] est_ff, est_in;
   logic [COUNT_WIDTH-1:0]              samples_ff, samples_in;
   logic [COUNT_WIDTH-1:0]              clips_ff, clips_in;

   logic signed [amh_pkg::SAMPLE_W-1:0] x;
   logic signed [amh_pkg::SAMPLE_W:0]   delta;
   logic signed [amh_pkg::SAMPLE_W:0]   step;
   logic signed [amh_pkg::SAMPLE_W:0]   est_sum;
   logic signed [amh_pkg::SAMPLE_W-1:0] est_new;
   logic signed [amh_pkg::SAMPLE_W:0]   diff;
   logic [amh_pkg::SAMPLE_W-1:0]        clamped;
   logic [amh_pkg::SAMPLE_W-1:0]        y;
   logic                                clip;
   logic                                accept;
   logic                                is_add;
   logic [COUNT_WIDTH-1:0]              samples_inc;
   logic [COUNT_WIDTH-1:0]              clips_inc;
   logic [EXT_W-1:0]                    samples_ext;
   logic [EXT_W-1:0]                    clips_ext;

   assign req.ready = !fifo_full && !clearing;
   assign accept    = req.valid && req.ready;
   assign is_add    = (req.operation == amh_pkg::OP_ADD);

   assign x    = req.sample_in;
   assign clip = (req.sample_in == amh_pkg::SAMPLE_MIN) ||
                 (req.sample_in == amh_pkg::SAMPLE_MAX);

   // leaky integrator: the estimate moves by delta >>> dc_shift
   assign delta   = $signed({x[amh_pkg::SAMPLE_W-1], x}) -
                    $signed({est_ff[amh_pkg::SAMPLE_W-1], est_ff});
   assign step    = delta >>> cfg.dc_shift;
   assign est_sum = $signed({est_ff[amh_pkg::SAMPLE_W-1], est_ff}) + step;
   assign est_new = est_sum[amh_pkg::SAMPLE_W-1:0];
   assign diff    = $signed({x[amh_pkg::SAMPLE_W-1], x}) -
                    $signed({est_new[amh_pkg::SAMPLE_W-1], est_new});

   always_comb begin
      if (diff[amh_pkg::SAMPLE_W] != diff[amh_pkg::SAMPLE_W-1]) begin
         clamped = diff[amh_pkg::SAMPLE_W] ? amh_pkg::SAMPLE_MIN : amh_pkg::SAMPLE_MAX;
      end else begin
         clamped = diff[amh_pkg::SAMPLE_W-1:0];
      end
      y = cfg.dc_block_enable ? clamped : x;
   end

   assign samples_inc = (&samples_ff) ? samples_ff : samples_ff + 1'b1;
   assign clips_inc   = (&clips_ff) ? clips_ff : clips_ff + 1'b1;

   always_comb begin
      est_in     = est_ff;
      samples_in = samples_ff;
      clips_in   = clips_ff;
      if (accept && is_add) begin
         samples_in = samples_inc;
         if (clip) begin
            clips_in = clips_inc;
         end
         if (cfg.dc_block_enable) begin
            est_in = est_new;
         end
      end
   end

   assign samples_ext = EXT_W'(samples_in);
   assign clips_ext   = EXT_W'(clips_in);

   assign push = accept;

   always_comb begin
      push_data.operation = req.operation;
      push_data.sample    = is_add ? y : '0;
      push_data.read_bin  = req.read_bin;
      push_data.clip      = is_add && clip;
      push_data.samples   = samples_ext[amh_pkg::COUNT_OUT_W-1:0];
      push_data.clips     = clips_ext[amh_pkg::COUNT_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff     <= '0;
         samples_ff <= '0;
         clips_ff   <= '0;
      end else begin
         est_ff     <= est_in;
         samples_ff <= samples_in;
         clips_ff   <= clips_in;
      end
   end

endmodule

FILE: rtl/amh_back.sv
// back end: noise gate, iterative bin divide, histogram memory update and
// the result register; clears the memory after reset. depends on amh_pkg, amh_if
`timescale 1ns / 1ps

module amh_back #(
   parameter int MAX_BINS    = 256,
   parameter int COUNT_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  amh_pkg::cfg_type   cfg,
   input  logic               fifo_empty,
   input  amh_pkg::entry_type pop_data,
   output logic               pop,
   output logic               clearing,
   amh_rsp_if.source          rsp
);

   localparam int IDX_W     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int IDX_EXT_W = (IDX_W > amh_pkg::BIN_OUT_W) ? IDX_W : amh_pkg::BIN_OUT_W;
   localparam int CNT_EXT_W = (COUNT_WIDTH > amh_pkg::COUNT_OUT_W) ?
                              COUNT_WIDTH : amh_pkg::COUNT_OUT_W;
   localparam int SW        = amh_pkg::SAMPLE_W;
   localparam int CW        = amh_pkg::CMP_W;

   amh_pkg::back_state_type        state_ff, state_in;
   amh_pkg::entry_type             entry_ff, entry_in;
   logic [SW-1:0]                  rem_ff, rem_in;
   logic [SW-1:0]                  quo_ff, quo_in;
   logic [amh_pkg::DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [IDX_W-1:0]               clr_ff, clr_in;
   logic [COUNT_WIDTH-1:0]         rd_data_ff;
   logic [COUNT_WIDTH-1:0]         mem_ff [MAX_BINS];

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [amh_pkg::BIN_OUT_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [amh_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [SW-1:0]                  rsp_sample_ff, rsp_sample_in;
   logic                           rsp_clip_ff, rsp_clip_in;
   logic [amh_pkg::COUNT_OUT_W-1:0] rsp_samples_ff, rsp_samples_in;
   logic [amh_pkg::COUNT_OUT_W-1:0] rsp_clips_ff, rsp_clips_in;

   logic [SW-1:0]                  width_eff;
   logic [CW-1:0]                  bins_used;
   logic [CW-1:0]                  last_bin;
   logic [CW-1:0]                  quo_wide;
   logic [IDX_W-1:0]               cap_idx;
   logic [CW-1:0]                  mag;
   logic                           gate_hit;
   logic [SW-1:0]                  gated_sample;
   logic [SW-1:0]                  dividend;
   logic [SW-1:0]                  rem_step;
   logic [SW-1:0]                  quo_step;
   logic [CW-1:0]                  trial;
   logic                           rd_en;
   logic                           mem_we;
   logic [IDX_W-1:0]               mem_waddr;
   logic [COUNT_WIDTH-1:0]         mem_wdata;
   logic [COUNT_WIDTH-1:0]         count_inc;
   logic [COUNT_WIDTH-1:0]         count_new;
   logic [IDX_EXT_W-1:0]           idx_ext;
   logic [CNT_EXT_W-1:0]           count_ext;
   logic                           out_free;

   assign width_eff = (cfg.bin_width == '0) ? SW'(1) : cfg.bin_width;

   // bins in use, forced into 1..MAX_BINS
   always_comb begin
      bins_used = CW'(cfg.bin_total);
      if (bins_used == '0) begin
         bins_used = CW'(1);
      end
      if (bins_used > CW'(MAX_BINS)) begin
         bins_used = CW'(MAX_BINS);
      end
      last_bin = bins_used - CW'(1);
   end

   assign quo_wide = CW'(quo_ff);
   assign cap_idx  = (quo_wide > last_bin) ? last_bin[IDX_W-1:0] : quo_wide[IDX_W-1:0];

   // gate on the magnitude; the most negative sample has magnitude 32768
   always_comb begin
      mag = pop_data.sample[SW-1] ? (CW'(0) - {1'b1, pop_data.sample})
                                  : {1'b0, pop_data.sample};
      gate_hit     = (cfg.gate_threshold != '0) && (mag < {1'b0, cfg.gate_threshold});
      gated_sample = gate_hit ? '0 : pop_data.sample;
      dividend     = gate_hit ? '0 : mag[SW-1:0];
   end

   // restoring divide, DIV_STEPS quotient bits per cycle
   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      trial    = '0;
      for (int i = 0; i < amh_pkg::DIV_STEPS; i++) begin
         trial = {rem_step, quo_step[SW-1]};
         if (trial >= {1'b0, width_eff}) begin
            trial    = trial - {1'b0, width_eff};
            quo_step = {quo_step[SW-2:0], 1'b1};
         end else begin
            quo_step = {quo_step[SW-2:0], 1'b0};
         end
         rem_step = trial[SW-1:0];
      end
   end

   assign count_inc = (&rd_data_ff) ? rd_data_ff : rd_data_ff + 1'b1;
   assign count_new = (entry_ff.operation == amh_pkg::OP_ADD) ? count_inc : rd_data_ff;
   assign idx_ext   = IDX_EXT_W'(idx_ff);
   assign count_ext = CNT_EXT_W'(count_new);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in       = state_ff;
      entry_in       = entry_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      div_cnt_in     = div_cnt_ff;
      idx_in         = idx_ff;
      clr_in         = clr_ff;
      pop            = 1'b0;
      rd_en          = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = count_new;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_index_in   = rsp_index_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_clip_in    = rsp_clip_ff;
      rsp_samples_in = rsp_samples_ff;
      rsp_clips_in   = rsp_clips_ff;

      case (state_ff)
         amh_pkg::BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(MAX_BINS - 1)) begin
               state_in = amh_pkg::BK_IDLE;
            end
         end
         amh_pkg::BK_IDLE: begin
            if (!fifo_empty) begin
               pop      = 1'b1;
               entry_in = pop_data;
               if (pop_data.operation == amh_pkg::OP_ADD) begin
                  entry_in.sample = gated_sample;
                  rem_in          = '0;
                  quo_in          = dividend;
                  div_cnt_in      = '0;
                  state_in        = amh_pkg::BK_DIV;
               end else begin
                  quo_in   = SW'(pop_data.read_bin);
                  state_in = amh_pkg::BK_READ;
               end
            end
         end
         amh_pkg::BK_DIV: begin
            rem_in     = rem_step;
            quo_in     = quo_step;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == amh_pkg::DIV_CNT_W'(amh_pkg::DIV_CYCLES - 1)) begin
               state_in = amh_pkg::BK_READ;
            end
         end
         amh_pkg::BK_READ: begin
            rd_en    = 1'b1;
            idx_in   = cap_idx;
            state_in = amh_pkg::BK_UPDATE;
         end
         amh_pkg::BK_UPDATE: begin
            if (out_free) begin
               mem_we         = (entry_ff.operation == amh_pkg::OP_ADD);
               rsp_valid_in   = 1'b1;
               rsp_index_in   = idx_ext[amh_pkg::BIN_OUT_W-1:0];
               rsp_count_in   = count_ext[amh_pkg::COUNT_OUT_W-1:0];
               rsp_sample_in  = entry_ff.sample;
               rsp_clip_in    = entry_ff.clip;
               rsp_samples_in = entry_ff.samples;
               rsp_clips_in   = entry_ff.clips;
               state_in       = amh_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = amh_pkg::BK_IDLE;
         end
      endcase
   end

   assign clearing = (state_ff == amh_pkg::BK_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= amh_pkg::BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff       <= entry_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      div_cnt_ff     <= div_cnt_in;
      idx_ff         <= idx_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_clip_ff    <= rsp_clip_in;
      rsp_samples_ff <= rsp_samples_in;
      rsp_clips_ff   <= rsp_clips_in;
   end

   // histogram memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[cap_idx];
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.bin_index      = rsp_index_ff;
   assign rsp.bin_count      = rsp_count_ff;
   assign rsp.cleaned_sample = rsp_sample_ff;
   assign rsp.clip_seen      = rsp_clip_ff;
   assign rsp.samples_total  = rsp_samples_ff;
   assign rsp.clips_total    = rsp_clips_ff;

endmodule

FILE: rtl/audio_magnitude_histogram_top.sv
// add: an accepted item goes through the queue and the back end's idle, bin divide,
// read and update states, the last of which registers the result; the back end
// takes no new item until then. read: idle, read and update (memory read and update)
// the 2-entry queue lets the front take items while the back end or output stalls
// after reset the histogram clear zeroes every bin with req_ch.ready low;
// register writes are taken at any time, registers reset to their defaults
`timescale 1ns / 1ps

module audio_magnitude_histogram_top #(
   parameter int MAX_BINS    = 256,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   amh_req_if.sink     req_ch,
   amh_rsp_if.source   rsp_ch,
   amh_csr_if.sink     csr_ch
);

   amh_pkg::cfg_type   cfg_ff, cfg_in;
   amh_pkg::entry_type push_data;
   amh_pkg::entry_type pop_data;
   logic               push;
   logic               pop;
   logic               fifo_full;
   logic               fifo_empty;
   logic               clearing;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            amh_pkg::CSR_DC_ENABLE: cfg_in.dc_block_enable = csr_ch.data[0];
            amh_pkg::CSR_DC_SHIFT:  cfg_in.dc_shift = csr_ch.data[amh_pkg::SHIFT_W-1:0];
            amh_pkg::CSR_GATE_THR:  cfg_in.gate_threshold = csr_ch.data;
            amh_pkg::CSR_BIN_WIDTH: cfg_in.bin_width = csr_ch.data;
            amh_pkg::CSR_BIN_TOTAL: cfg_in.bin_total = csr_ch.data[amh_pkg::BIN_TOTAL_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dc_block_enable <= 1'b0;
         cfg_ff.dc_shift        <= '0;
         cfg_ff.gate_threshold  <= '0;
         cfg_ff.bin_width       <= amh_pkg::SAMPLE_W'(1);
         cfg_ff.bin_total       <= amh_pkg::BIN_TOTAL_W'(256);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   amh_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cfg       (cfg_ff),
      .fifo_full (fifo_full),
      .clearing  (clearing),
      .push      (push),
      .push_data (push_data)
   );

   amh_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (fifo_empty)
   );

   amh_back #(
      .MAX_BINS    (MAX_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_empty (fifo_empty),
      .pop_data   (pop_data),
      .pop        (pop),
      .clearing   (clearing),
      .rsp        (rsp_ch)
   );

endmodule

FILE: rtl/amh_checker.sv
// port-level checks of the audio magnitude histogram top, attached by bind
// depends on amh_pkg and the top level's channel interfaces
`timescale 1ns / 1ps

module amh_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [amh_pkg::BIN_OUT_W-1:0]       rsp_bin_index,
   input logic [amh_pkg::COUNT_OUT_W-1:0]     rsp_bin_count,
   input logic [amh_pkg::SAMPLE_W-1:0]        rsp_cleaned_sample,
   input logic [amh_pkg::COUNT_OUT_W-1:0]     rsp_samples_total
);

   // items taken but not yet answered
   logic [3:0] pending_ff, pending_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_index) &&
      $stable(rsp_bin_count) && $stable(rsp_cleaned_sample) && $stable(rsp_samples_total))
      else $error("result changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without a pending item");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("item taken before histogram clear");

endmodule

bind audio_magnitude_histogram_top amh_checker u_amh_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_bin_index      (rsp_ch.bin_index),
   .rsp_bin_count      (rsp_ch.bin_count),
   .rsp_cleaned_sample (rsp_ch.cleaned_sample),
   .rsp_samples_total  (rsp_ch.samples_total)
);
